// ===== rtl/efi_pkg.sv =====
package efi_pkg;

  // Field widths
  localparam int COORD_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;

  // Q4.x fixed point: four integer bits including sign
  localparam int FRAC_BITS = COORD_WIDTH - 4;

  // Iterate holds one extra integer bit, so its magnitude fits COORD_WIDTH bits
  localparam int Z_WIDTH    = COORD_WIDTH + 1;
  localparam int MAG_WIDTH  = COORD_WIDTH;
  localparam int PROD_WIDTH = 2 * MAG_WIDTH;

  // |z|^2 >= 4 once any bit at or above this weight is set in the exact sum
  localparam int ESC_BIT = 2 * FRAC_BITS + 2;

  // Configuration channel
  localparam int CFG_IDX_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FRACTAL_MODE    = CFG_IDX_WIDTH'(0),
    REG_JULIA_C_REAL    = CFG_IDX_WIDTH'(1),
    REG_JULIA_C_IMAG    = CFG_IDX_WIDTH'(2),
    REG_ITERATION_LIMIT = CFG_IDX_WIDTH'(3)
  } cfg_reg_e;

  typedef enum logic {
    MODE_MANDELBROT = 1'b0,
    MODE_JULIA      = 1'b1
  } fractal_mode_e;

  // Reset values: c near 0.285 - 0.01i (imaginary part rounded towards minus infinity)
  localparam logic signed [COORD_WIDTH-1:0] JULIA_C_REAL_RESET =
    COORD_WIDTH'(76503654);
  localparam logic signed [COORD_WIDTH-1:0] JULIA_C_IMAG_RESET =
    COORD_WIDTH'(-(((longint'(1) <<< FRAC_BITS) + 99) / 100));
  localparam logic [COUNT_WIDTH-1:0] ITERATION_LIMIT_RESET = COUNT_WIDTH'(2000);

  typedef struct packed {
    fractal_mode_e                  mode;
    logic signed [COORD_WIDTH-1:0]  c_real;
    logic signed [COORD_WIDTH-1:0]  c_imag;
    logic [COUNT_WIDTH-1:0]         limit;
  } efi_cfg_t;

  // Magnitude of an iterate; the most negative code is never reached
  function automatic logic [MAG_WIDTH-1:0] efi_mag(input logic signed [Z_WIDTH-1:0] z);
    logic signed [Z_WIDTH-1:0] n;
    n = -z;
    return z[Z_WIDTH-1] ? MAG_WIDTH'(n) : MAG_WIDTH'(z);
  endfunction

endpackage

// ===== rtl/efi_if.sv =====
// Input point channel
interface efi_in_if;
  import efi_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_real;
  logic signed [COORD_WIDTH-1:0] point_imag;
  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

// Result channel
interface efi_out_if;
  import efi_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] iteration_count;
  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

// Configuration write channel
interface efi_cfg_if;
  import efi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/efi_cfg.sv =====
module efi_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  efi_cfg_if.sink           cfg_i,
  output efi_pkg::efi_cfg_t cfg_o
);
  import efi_pkg::*;

  efi_cfg_t regs_q;

  // Always take writes
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  // Update the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.mode   <= MODE_JULIA;
      regs_q.c_real <= JULIA_C_REAL_RESET;
      regs_q.c_imag <= JULIA_C_IMAG_RESET;
      regs_q.limit  <= ITERATION_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_FRACTAL_MODE:    regs_q.mode   <= fractal_mode_e'(cfg_i.data[0]);
        REG_JULIA_C_REAL:    regs_q.c_real <= cfg_i.data[COORD_WIDTH-1:0];
        REG_JULIA_C_IMAG:    regs_q.c_imag <= cfg_i.data[COORD_WIDTH-1:0];
        REG_ITERATION_LIMIT: regs_q.limit  <= cfg_i.data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/efi_mul.sv =====
module efi_mul (
  input  logic                           clk_i,
  input  logic [efi_pkg::MAG_WIDTH-1:0]  a_i,
  input  logic [efi_pkg::MAG_WIDTH-1:0]  b_i,
  output logic [efi_pkg::PROD_WIDTH-1:0] prod_o
);
  import efi_pkg::*;

  logic [PROD_WIDTH-1:0] prod_q;

  // Exact unsigned product, registered
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/escape_time_fractal_iterator.sv =====
// Escape-time iterator for Mandelbrot and Julia sets. Each point transaction
// (signed Q4.28) starts z at the point and repeats z = z*z + c until |z|^2 >= 4
// or the count reaches iteration_limit; one result transaction returns the count.
// Mandelbrot mode takes c from the point, Julia mode from the two c registers.
// All products are exact and truncated towards minus infinity after scaling.
// A single 32x32 multiplier is shared for x*x, y*y and x*y, so each iteration
// steps through the states SQX, SQY and TEST; a finished point waits in FIN
// until the output register is free before its result is offered. The input
// is not ready while a point is in progress; a finished result waits in an
// output register while the next point is taken. Configuration writes are
// always accepted and must only be issued while no point is in flight.
module escape_time_fractal_iterator (
  input  logic      clk_i,
  input  logic      rst_ni,
  efi_cfg_if.sink   cfg_i,
  efi_in_if.sink    in_i,
  efi_out_if.source out_o
);
  import efi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_TEST,
    ST_FIN
  } state_e;

  state_e                    state_q;
  efi_cfg_t                  cfg;
  logic signed [Z_WIDTH-1:0] x_q, y_q, cx_q, cy_q;
  logic signed [Z_WIDTH-1:0] x_upd, y_upd;
  logic [PROD_WIDTH-1:0]     xx_q, prod;
  logic [PROD_WIDTH:0]       mag_sum;
  logic signed [PROD_WIDTH:0] diff, xy_s;
  logic                      neg_q, y_pend_q;
  logic [COUNT_WIDTH-1:0]    count_q, res_q;
  logic                      out_valid_q;
  logic [MAG_WIDTH-1:0]      mag_x, mag_y, op_a, op_b;
  logic                      escaped, done, out_free, load, finish;

  efi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  efi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // Pick multiplier operands for this step
  assign mag_x = efi_mag(x_q);
  assign mag_y = efi_mag(y_q);

  always_comb begin
    unique case (state_q)
      ST_SQX: begin
        op_a = mag_x;
        op_b = mag_x;
      end
      ST_SQY: begin
        op_a = mag_y;
        op_b = mag_y;
      end
      default: begin
        op_a = mag_x;
        op_b = mag_y;
      end
    endcase
  end

  // Escape test on the exact sum of squares (y*y arrives from the multiplier)
  assign mag_sum = {1'b0, xx_q} + {1'b0, prod};
  assign escaped = |mag_sum[PROD_WIDTH:ESC_BIT];
  assign done    = escaped || (count_q >= cfg.limit);

  // New real part from x*x - y*y, new imaginary part from the signed x*y
  assign diff  = $signed({1'b0, xx_q}) - $signed({1'b0, prod});
  assign x_upd = Z_WIDTH'(diff >>> FRAC_BITS) + cx_q;
  assign xy_s  = neg_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign y_upd = Z_WIDTH'(xy_s >>> (FRAC_BITS - 1)) + cy_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign load     = (state_q == ST_IDLE) && in_i.valid;
  assign finish   = out_free && (((state_q == ST_TEST) && done) || (state_q == ST_FIN));

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.iteration_count = res_q;

  // Sequencer, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      y_pend_q    <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            count_q  <= '0;
            y_pend_q <= 1'b0;
            state_q  <= ST_SQX;
          end
        end
        ST_SQX: begin
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          if (done) begin
            if (out_free) begin
              res_q       <= count_q;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              state_q <= ST_FIN;
            end
          end else begin
            count_q  <= count_q + 1'b1;
            y_pend_q <= 1'b1;
            state_q  <= ST_SQX;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            res_q       <= count_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Iterate and constant registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q <= Z_WIDTH'(in_i.point_real);
      y_q <= Z_WIDTH'(in_i.point_imag);
      if (cfg.mode == MODE_JULIA) begin
        cx_q <= Z_WIDTH'(cfg.c_real);
        cy_q <= Z_WIDTH'(cfg.c_imag);
      end else begin
        cx_q <= Z_WIDTH'(in_i.point_real);
        cy_q <= Z_WIDTH'(in_i.point_imag);
      end
    end
    // Finish the previous iteration's imaginary part while x*x is formed
    if (state_q == ST_SQX && y_pend_q) begin
      y_q <= y_upd;
    end
    if (state_q == ST_SQY) begin
      xx_q <= prod;
    end
    if (state_q == ST_TEST && !done) begin
      x_q   <= x_upd;
      neg_q <= x_q[Z_WIDTH-1] ^ y_q[Z_WIDTH-1];
    end
  end

endmodule

// ===== verif/tb_escape_time_fractal_iterator.sv =====
`timescale 1ns / 100ps

module tb_escape_time_fractal_iterator;
  import efi_pkg::*;

  // Register state after reset: Julia mode, c = 0.285 - 0.01i, 2000 iterations
  localparam logic signed [COORD_WIDTH-1:0] C_REAL_AT_RESET = 32'sd76503654;
  localparam logic signed [COORD_WIDTH-1:0] C_IMAG_AT_RESET = -32'sd2684355;
  localparam logic [COUNT_WIDTH-1:0]        LIMIT_AT_RESET  = 16'd2000;

  // Index that decodes to no register
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED = 8'd9;

  // Fixed-point landmarks in Q4.28
  localparam logic [COORD_WIDTH-1:0] Q_ZERO     = 32'h0000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_TWO      = 32'h2000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_MINUS_TWO = 32'hE000_0000;
  localparam logic [COORD_WIDTH-1:0] Q_HALF     = 32'h0800_0000;
  localparam logic [COORD_WIDTH-1:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [COORD_WIDTH-1:0] Q_MIN      = 32'h8000_0000;

  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 36;
  localparam int STORE_DEPTH      = 1024;
  localparam int unsigned STALL_LIMIT = 800_000;

  typedef enum logic { JOB_POINT, JOB_WRITE } job_kind_e;

  typedef struct packed {
    job_kind_e                 kind;
    logic [CFG_IDX_WIDTH-1:0]  reg_index;
    logic [CFG_DATA_WIDTH-1:0] reg_data;
    logic [COORD_WIDTH-1:0]    re;
    logic [COORD_WIDTH-1:0]    im;
  } job_t;

  logic clk = 1'b0;
  logic rst_n;

  efi_cfg_if cfg_bus ();
  efi_in_if  pt_bus ();
  efi_out_if res_bus ();

  escape_time_fractal_iterator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (pt_bus),
    .out_o  (res_bus)
  );

  // Predictor copy of the registers
  fractal_mode_e                 mode_cfg;
  logic signed [COORD_WIDTH-1:0] c_re_cfg;
  logic signed [COORD_WIDTH-1:0] c_im_cfg;
  logic [COUNT_WIDTH-1:0]        limit_cfg;

  job_t                   pending_jobs[$];
  logic [COUNT_WIDTH-1:0] expected_counts [0:STORE_DEPTH-1];
  int unsigned            pts_accepted;
  int unsigned            results_seen;

  logic        pt_active;
  logic        cfg_active;
  int unsigned drv_gap;
  int unsigned drv_calm;
  int unsigned mon_stall;
  int unsigned mon_calm;
  int unsigned quiet_cycles;

  int unsigned error_count = 0;
  int unsigned mandel_points = 0;
  int unsigned julia_points = 0;
  int unsigned writes_done = 0;
  int unsigned deepest_count = 0;

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wait before the next transaction; runs of zero waits give stretches at full rate
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 24);
    return $urandom_range(0, 8);
  endfunction

  // Escape-time count for one point under the current register copy
  function automatic logic [COUNT_WIDTH-1:0] escape_count(input logic [COORD_WIDTH-1:0] pr,
                                                         input logic [COORD_WIDTH-1:0] pi);
    logic signed [127:0] zr, zi, cr, ci, rr, ii, ri, radius_sq;
    int unsigned n;
    bit          escaped;
    zr = signed'(pr);
    zi = signed'(pi);
    if (mode_cfg == MODE_JULIA) begin
      cr = c_re_cfg;
      ci = c_im_cfg;
    end else begin
      cr = zr;
      ci = zi;
    end
    radius_sq = 128'sd1 <<< ESC_BIT;
    n = 0;
    escaped = 1'b0;
    // Exact squares; new parts floored after scaling back
    while (!escaped && n < limit_cfg) begin
      rr = zr * zr;
      ii = zi * zi;
      if (rr + ii >= radius_sq) begin
        escaped = 1'b1;
      end else begin
        ri = zr * zi;
        zi = ((ri <<< 1) >>> FRAC_BITS) + ci;
        zr = ((rr - ii) >>> FRAC_BITS) + cr;
        n++;
      end
    end
    return COUNT_WIDTH'(n);
  endfunction

  function automatic void queue_point(input logic [COORD_WIDTH-1:0] re,
                                      input logic [COORD_WIDTH-1:0] im);
    job_t j;
    j = '0;
    j.kind = JOB_POINT;
    j.re = re;
    j.im = im;
    pending_jobs.push_back(j);
  endfunction

  function automatic void queue_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                                      input logic [CFG_DATA_WIDTH-1:0] data);
    job_t j;
    j = '0;
    j.kind = JOB_WRITE;
    j.reg_index = idx;
    j.reg_data = data;
    pending_jobs.push_back(j);
  endfunction

  // Mostly inside the radius-two box, some inside the unit box, some anywhere
  function automatic logic [COORD_WIDTH-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom;
    if (pick <= 6) return COORD_WIDTH'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
    return COORD_WIDTH'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
  endfunction

  // Driver: feed points and register writes; writes only once every result is back
  always @(posedge clk) begin
    job_t j;
    logic pt_fire;
    if (!rst_n) begin
      pt_active = 1'b0;
      cfg_active = 1'b0;
      drv_gap = 0;
      drv_calm = 0;
      pts_accepted <= 0;
      mode_cfg = MODE_JULIA;
      c_re_cfg = C_REAL_AT_RESET;
      c_im_cfg = C_IMAG_AT_RESET;
      limit_cfg = LIMIT_AT_RESET;
      pt_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      pt_fire = pt_bus.valid && pt_bus.ready;
      if (pt_fire) begin
        expected_counts[pts_accepted % STORE_DEPTH] <=
          escape_count(pt_bus.point_real, pt_bus.point_imag);
        pts_accepted <= pts_accepted + 1;
        if (mode_cfg == MODE_JULIA) julia_points++;
        else mandel_points++;
        pt_active = 1'b0;
        drv_gap = draw_wait(drv_calm);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_FRACTAL_MODE:    mode_cfg = fractal_mode_e'(cfg_bus.data[0]);
          REG_JULIA_C_REAL:    c_re_cfg = cfg_bus.data[COORD_WIDTH-1:0];
          REG_JULIA_C_IMAG:    c_im_cfg = cfg_bus.data[COORD_WIDTH-1:0];
          REG_ITERATION_LIMIT: limit_cfg = cfg_bus.data[COUNT_WIDTH-1:0];
          default: ;
        endcase
        writes_done++;
        cfg_active = 1'b0;
        drv_gap = draw_wait(drv_calm);
      end
      // Launch the next transaction once the gap has run out
      if (!pt_active && !cfg_active) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_jobs.size() != 0) begin
          j = pending_jobs[0];
          if (j.kind == JOB_POINT) begin
            void'(pending_jobs.pop_front());
            pt_bus.point_real <= j.re;
            pt_bus.point_imag <= j.im;
            pt_active = 1'b1;
          end else if (!pt_fire && pts_accepted == results_seen) begin
            void'(pending_jobs.pop_front());
            cfg_bus.index <= j.reg_index;
            cfg_bus.data <= j.reg_data;
            cfg_active = 1'b1;
          end
        end
      end
      pt_bus.valid <= pt_active;
      cfg_bus.valid <= cfg_active;
    end
  end

  // Monitor: stall at random, check each count against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      mon_stall = 0;
      mon_calm = 0;
      results_seen <= 0;
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (results_seen >= pts_accepted) begin
          $error("iteration_count: expected none, got %0d", res_bus.iteration_count);
          error_count++;
        end else begin
          if (res_bus.iteration_count !== expected_counts[results_seen % STORE_DEPTH]) begin
            $error("iteration_count: expected %0d, got %0d",
                   expected_counts[results_seen % STORE_DEPTH], res_bus.iteration_count);
            error_count++;
          end
          results_seen <= results_seen + 1;
        end
        if (res_bus.iteration_count > deepest_count) deepest_count = res_bus.iteration_count;
        mon_stall = draw_wait(mon_calm);
      end else if (mon_stall > 0) begin
        mon_stall--;
      end
      res_bus.ready <= (mon_stall == 0);
    end
  end

  // Watchdog: end the run if no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned k;
    int unsigned lim;
    rst_n = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pt_bus.valid = 1'b0;
    pt_bus.point_real = '0;
    pt_bus.point_imag = '0;
    res_bus.ready = 1'b0;

    // Reset settings: origin and the coordinate extremes
    queue_point(Q_ZERO, Q_ZERO);
    queue_point(Q_MAX, Q_MAX);
    queue_point(Q_MIN, Q_MIN);
    queue_point(Q_MIN, Q_MAX);

    // Limit of zero returns zero even inside the set
    queue_write(REG_ITERATION_LIMIT, 32'd0);
    queue_point(Q_ZERO, Q_ZERO);
    queue_point(Q_HALF, Q_ZERO);

    // Upper register bits ignored, unmapped index ignored
    queue_write(REG_FRACTAL_MODE, 32'hFFFF_FFFE);
    queue_write(REG_UNMAPPED, 32'h1234_5679);
    queue_write(REG_ITERATION_LIMIT, 32'hFFFF_0001);
    queue_point(Q_ZERO, Q_ZERO);
    queue_point(Q_TWO, Q_ZERO);
    queue_point(Q_ZERO, Q_MINUS_TWO);
    queue_point(32'h1FFF_FFFF, Q_ZERO);

    // Largest limit: origin never escapes, radius two escapes at once
    queue_write(REG_ITERATION_LIMIT, 32'd65535);
    queue_point(Q_ZERO, Q_ZERO);
    queue_point(Q_MINUS_TWO, Q_ZERO);
    queue_point(Q_HALF, Q_HALF);

    // Julia with the extreme constant: escapes after one step
    queue_write(REG_FRACTAL_MODE, CFG_DATA_WIDTH'(MODE_JULIA));
    queue_write(REG_JULIA_C_REAL, 32'h7FFF_FFFF);
    queue_write(REG_JULIA_C_IMAG, 32'h8000_0000);
    queue_point(Q_ZERO, Q_ZERO);
    queue_point(random_coord(), random_coord());

    // Random phases: new settings, then well-formed points with some noise
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 3) lim = 2000;
      else if (phase == RANDOM_PHASES - 1) lim = 1;
      else lim = $urandom_range(1, 256);
      queue_write(REG_FRACTAL_MODE, ($urandom & 32'hFFFF_FFFE) | (phase % 2));
      if ($urandom_range(0, 3) == 0) begin
        queue_write(REG_JULIA_C_REAL, $urandom);
        queue_write(REG_JULIA_C_IMAG, $urandom);
      end else begin
        queue_write(REG_JULIA_C_REAL,
                    CFG_DATA_WIDTH'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
        queue_write(REG_JULIA_C_IMAG,
                    CFG_DATA_WIDTH'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
      end
      queue_write(REG_ITERATION_LIMIT, ($urandom & 32'hFFFF_0000) | lim);
      for (k = 0; k < POINTS_PER_PHASE; k++) queue_point(random_coord(), random_coord());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and every result back
    do @(negedge clk);
    while (!(pending_jobs.size() == 0 && !pt_active && !cfg_active &&
             pts_accepted == results_seen));
    repeat (16) @(negedge clk);

    $display("Covered %0d Mandelbrot and %0d Julia points across %0d register writes",
             mandel_points, julia_points, writes_done);
    $display("Deepest count returned: %0d, mismatches: %0d", deepest_count, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/efi_pkg.sv
rtl/efi_if.sv
rtl/efi_cfg.sv
rtl/efi_mul.sv
rtl/escape_time_fractal_iterator.sv
verif/tb_escape_time_fractal_iterator.sv
